FILE: hdl/lfumt_pkg.sv
`timescale 1ns / 1ps

package lfumt_pkg;

  localparam int NUM_WAYS_DEF   = 8;
  localparam int NUM_SETS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam int OP_W       = 2;
  localparam int SET_IDX_W  = 6;
  localparam int WAY_IDX_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INVAL  = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_FILL   = 2'd2,
    OP_VICTIM = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MASK,
    ST_SEL
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic                 set_ok;
    logic                 way_ok;
    logic [SET_IDX_W-1:0] set;
    logic [WAY_IDX_W-1:0] way;
  } cmd_t;

endpackage

FILE: hdl/lfu_median_tie_victim_select.sv
`timescale 1ns / 1ps
// Least-frequently-used replacement with a median tie-break among the coldest ways.
// An item is offered on op_i, set_index_i and way_index_i with start_i, and is
// taken at a rising edge where start_i is high and busy_o is low. Items enter a
// two-entry queue; busy_o is high while that queue is full.
// Every item yields one result, shown on victim_way_o and victim_valid_o for a
// single cycle with done_o high. The receiver cannot stall; results are never held.
// Invalidate, touch and fill read the set row, update one count and write the row
// back; with the set or the way out of range the row is left as it was. A victim
// request reads the row, takes the minimum, marks the tied ways and selects the
// median one; with the set out of range it gives way 0 with victim_valid_o high.
// The single-port count memory holds one row per set; each item reads its row and
// finishes before the next begins.
// After reset the count memory is zeroed one row per cycle, with busy_o high
// throughout; results come out in acceptance order.
module lfu_median_tie_victim_select #(
  parameter int NUM_WAYS   = lfumt_pkg::NUM_WAYS_DEF,
  parameter int NUM_SETS   = lfumt_pkg::NUM_SETS_DEF,
  parameter int COUNT_BITS = lfumt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lfumt_pkg::OP_W-1:0]      op_i,
  input  logic [lfumt_pkg::SET_IDX_W-1:0] set_index_i,
  input  logic [lfumt_pkg::WAY_IDX_W-1:0] way_index_i,
  output logic                            done_o,
  output logic [lfumt_pkg::WAY_IDX_W-1:0] victim_way_o,
  output logic                            victim_valid_o
);

  logic            clearing;
  logic            pop;
  logic            cmd_valid;
  lfumt_pkg::cmd_t cmd;

  lfumt_front #(
    .NUM_WAYS (NUM_WAYS),
    .NUM_SETS (NUM_SETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .set_index_i (set_index_i),
    .way_index_i (way_index_i),
    .clearing_i  (clearing),
    .pop_i       (pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  lfumt_back #(
    .NUM_WAYS   (NUM_WAYS),
    .NUM_SETS   (NUM_SETS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .done_o         (done_o),
    .victim_way_o   (victim_way_o),
    .victim_valid_o (victim_valid_o)
  );

endmodule

FILE: hdl/lfumt_front.sv
`timescale 1ns / 1ps

module lfumt_front #(
  parameter int NUM_WAYS = lfumt_pkg::NUM_WAYS_DEF,
  parameter int NUM_SETS = lfumt_pkg::NUM_SETS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lfumt_pkg::OP_W-1:0]      op_i,
  input  logic [lfumt_pkg::SET_IDX_W-1:0] set_index_i,
  input  logic [lfumt_pkg::WAY_IDX_W-1:0] way_index_i,
  input  logic                            clearing_i,
  input  logic                            pop_i,
  output logic                            cmd_valid_o,
  output lfumt_pkg::cmd_t                 cmd_o
);

  lfumt_pkg::cmd_t queue_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  lfumt_pkg::cmd_t cmd_in;

  // Each item is classified on entry so that the back end needs no range checks.
  always_comb begin
    cmd_in.op     = lfumt_pkg::op_e'(op_i);
    cmd_in.set_ok = 32'(set_index_i) < NUM_SETS;
    cmd_in.way_ok = 32'(way_index_i) < NUM_WAYS;
    cmd_in.set    = set_index_i;
    cmd_in.way    = way_index_i;
  end

  assign busy_o      = (count_q == 2'd2) || clearing_i;
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = count_q != 2'd0;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: hdl/lfumt_back.sv
`timescale 1ns / 1ps

module lfumt_back #(
  parameter int NUM_WAYS   = lfumt_pkg::NUM_WAYS_DEF,
  parameter int NUM_SETS   = lfumt_pkg::NUM_SETS_DEF,
  parameter int COUNT_BITS = lfumt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  lfumt_pkg::cmd_t                 cmd_i,
  output logic                            pop_o,
  output logic                            clearing_o,
  output logic                            done_o,
  output logic [lfumt_pkg::WAY_IDX_W-1:0] victim_way_o,
  output logic                            victim_valid_o
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int NP2   = 1 << WAY_W;
  localparam int CNT_W = $clog2(NUM_WAYS + 1);

  typedef logic [NUM_WAYS-1:0][COUNT_BITS-1:0] row_t;

  row_t                  mem_q [NUM_SETS];
  row_t                  rd_q;
  row_t                  wr_row;
  logic                  rd_en;
  logic [SET_W-1:0]      rd_addr;
  logic                  we;
  logic [SET_W-1:0]      waddr;
  row_t                  wdata;

  lfumt_pkg::state_e     state_q, state_d;
  lfumt_pkg::cmd_t       cmd_q, cmd_d;
  logic                  clr_q, clr_d;
  logic [SET_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic [COUNT_BITS-1:0] min_q, min_d;
  logic [NUM_WAYS-1:0]   mask_q, mask_d;
  logic [CNT_W-1:0]      tgt_q, tgt_d;
  logic                  done_q, done_d;
  logic [lfumt_pkg::WAY_IDX_W-1:0] way_q, way_d;
  logic                  vvalid_q, vvalid_d;

  logic [COUNT_BITS-1:0] tree [WAY_W+1][NP2];
  logic [CNT_W-1:0]      pop_cnt;
  logic [CNT_W-1:0]      seen;
  logic                  found;
  logic [WAY_W-1:0]      sel;
  logic [COUNT_BITS-1:0] cur;

  assign clearing_o     = clr_q;
  assign done_o         = done_q;
  assign victim_way_o   = way_q;
  assign victim_valid_o = vvalid_q;

  // Minimum of the row as a balanced tree; padding leaves hold the largest count.
  always_comb begin
    tree = '{default: '0};
    for (int i = 0; i < NP2; i++) begin
      if (i < NUM_WAYS) begin
        tree[0][i] = rd_q[i];
      end else begin
        tree[0][i] = '1;
      end
    end
    for (int l = 1; l <= WAY_W; l++) begin
      for (int i = 0; i < (NP2 >> l); i++) begin
        if (tree[l-1][2*i+1] < tree[l-1][2*i]) begin
          tree[l][i] = tree[l-1][2*i+1];
        end else begin
          tree[l][i] = tree[l-1][2*i];
        end
      end
    end
  end

  always_comb begin
    pop_cnt = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      pop_cnt = pop_cnt + CNT_W'(rd_q[i] == min_q);
    end
  end

  // The way at the median position among the tied ways.
  always_comb begin
    seen  = '0;
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (mask_q[i]) begin
        if (!found && seen == tgt_q) begin
          sel   = WAY_W'(i);
          found = 1'b1;
        end
        seen = seen + CNT_W'(1);
      end
    end
  end

  always_comb begin
    wr_row = rd_q;
    cur    = rd_q[WAY_W'(cmd_q.way)];
    case (cmd_q.op)
      lfumt_pkg::OP_INVAL: wr_row[WAY_W'(cmd_q.way)] = '0;
      lfumt_pkg::OP_TOUCH: begin
        if (!(&cur)) begin
          wr_row[WAY_W'(cmd_q.way)] = cur + COUNT_BITS'(1);
        end
      end
      lfumt_pkg::OP_FILL:  wr_row[WAY_W'(cmd_q.way)] = COUNT_BITS'(1);
      default:             wr_row = rd_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    min_d     = min_q;
    mask_d    = mask_q;
    tgt_d     = tgt_q;
    done_d    = 1'b0;
    way_d     = '0;
    vvalid_d  = 1'b0;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = wr_row;

    if (clr_q) begin
      we        = 1'b1;
      waddr     = clr_cnt_q;
      wdata     = '0;
      clr_cnt_d = clr_cnt_q + SET_W'(1);
      if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
        clr_d = 1'b0;
      end
    end

    case (state_q)
      lfumt_pkg::ST_IDLE: begin
        if (!clr_q && cmd_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          rd_en   = 1'b1;
          rd_addr = cmd_i.set_ok ? SET_W'(cmd_i.set) : '0;
          state_d = lfumt_pkg::ST_EXEC;
        end
      end
      lfumt_pkg::ST_EXEC: begin
        if (cmd_q.op == lfumt_pkg::OP_VICTIM) begin
          if (cmd_q.set_ok) begin
            min_d   = tree[WAY_W][0];
            state_d = lfumt_pkg::ST_MASK;
          end else begin
            done_d   = 1'b1;
            vvalid_d = 1'b1;
            state_d  = lfumt_pkg::ST_IDLE;
          end
        end else begin
          if (cmd_q.set_ok && cmd_q.way_ok) begin
            we    = 1'b1;
            waddr = SET_W'(cmd_q.set);
            wdata = wr_row;
          end
          done_d  = 1'b1;
          state_d = lfumt_pkg::ST_IDLE;
        end
      end
      lfumt_pkg::ST_MASK: begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          mask_d[i] = rd_q[i] == min_q;
        end
        tgt_d   = pop_cnt >> 1;
        state_d = lfumt_pkg::ST_SEL;
      end
      lfumt_pkg::ST_SEL: begin
        done_d   = 1'b1;
        vvalid_d = 1'b1;
        way_d    = lfumt_pkg::WAY_IDX_W'(sel);
        state_d  = lfumt_pkg::ST_IDLE;
      end
      default: state_d = lfumt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfumt_pkg::ST_IDLE;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
      vvalid_q  <= 1'b0;
      way_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
      vvalid_q  <= vvalid_d;
      way_q     <= way_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    min_q  <= min_d;
    mask_q <= mask_d;
    tgt_q  <= tgt_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

endmodule

FILE: tb/tb_lfu_median_tie_victim_select.sv
`timescale 1ns / 1ps

module tb_lfu_median_tie_victim_select;

  localparam int WAYS = lfumt_pkg::NUM_WAYS_DEF;
  localparam int SETS = lfumt_pkg::NUM_SETS_DEF;
  localparam int CNT_W = lfumt_pkg::COUNT_BITS_DEF;
  localparam int OP_BITS = lfumt_pkg::OP_W;
  localparam int SET_BITS = lfumt_pkg::SET_IDX_W;
  localparam int WAY_BITS = lfumt_pkg::WAY_IDX_W;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HEAVY_TOUCHES = 20;

  typedef struct {
    logic [WAY_BITS-1:0] way;
    logic                valid;
  } answer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [OP_BITS-1:0]  op_i = '0;
  logic [SET_BITS-1:0] set_index_i = '0;
  logic [WAY_BITS-1:0] way_index_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [WAY_BITS-1:0] victim_way_o;
  logic                victim_valid_o;

  logic [CNT_W-1:0] visit_cnt [SETS][WAYS];
  answer_t          answers_due[$];
  int               errors = 0;
  int unsigned      cycles = 0;
  bit               idle_on = 1'b1;

  lfu_median_tie_victim_select uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .set_index_i    (set_index_i),
    .way_index_i    (way_index_i),
    .done_o         (done_o),
    .victim_way_o   (victim_way_o),
    .victim_valid_o (victim_valid_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report(string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // The way at the middle position among the ways holding the lowest count.
  function automatic logic [WAY_BITS-1:0] median_coldest(int s);
    logic [CNT_W-1:0]    low;
    int                  ties;
    int                  seen;
    logic [WAY_BITS-1:0] pick;
    low = visit_cnt[s][0];
    for (int w = 1; w < WAYS; w++) begin
      if (visit_cnt[s][w] < low) low = visit_cnt[s][w];
    end
    ties = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (visit_cnt[s][w] == low) ties++;
    end
    seen = 0;
    pick = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (visit_cnt[s][w] == low) begin
        if (seen == ties / 2) pick = w[WAY_BITS-1:0];
        seen++;
      end
    end
    return pick;
  endfunction

  task automatic apply_item(lfumt_pkg::op_e op, int s, int w);
    answer_t ans;
    ans.way = '0;
    ans.valid = 1'b0;
    if (op == lfumt_pkg::OP_VICTIM) begin
      ans.valid = 1'b1;
      if (s < SETS) ans.way = median_coldest(s);
    end else if (s < SETS && w < WAYS) begin
      case (op)
        lfumt_pkg::OP_INVAL: visit_cnt[s][w] = '0;
        lfumt_pkg::OP_TOUCH: begin
          if (visit_cnt[s][w] != CNT_TOP) visit_cnt[s][w] = visit_cnt[s][w] + 1'b1;
        end
        default: visit_cnt[s][w] = CNT_W'(1);
      endcase
    end
    answers_due.push_back(ans);
  endtask

  task automatic send_item(lfumt_pkg::op_e op, logic [SET_BITS-1:0] s,
                           logic [WAY_BITS-1:0] w);
    @(negedge clk_i);
    start_i = 1'b1;
    op_i = op;
    set_index_i = s;
    way_index_i = w;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    apply_item(op, s, w);
  endtask

  task automatic pause(int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_pause();
    if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 18));
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    answer_t due;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_ni) begin
      if ($isunknown(done_o)) begin
        report("done_o is unknown");
      end else if (done_o) begin
        if (answers_due.size() == 0) begin
          report($sformatf("result with no item outstanding: way %0d valid %0b",
                           victim_way_o, victim_valid_o));
        end else begin
          due = answers_due.pop_front();
          if (victim_way_o !== due.way)
            report($sformatf("victim_way_o %0d, predicted %0d", victim_way_o, due.way));
          if (victim_valid_o !== due.valid)
            report($sformatf("victim_valid_o %0b, predicted %0b",
                             victim_valid_o, due.valid));
        end
      end
    end
  end

  task automatic test_reset_state();
    send_item(lfumt_pkg::OP_VICTIM, 6'd0, 3'd0);
    send_item(lfumt_pkg::OP_VICTIM, 6'd63, 3'd7);
    settle();
  endtask

  task automatic test_each_operation();
    send_item(lfumt_pkg::OP_FILL, 6'd63, 3'd7);
    send_item(lfumt_pkg::OP_VICTIM, 6'd63, 3'd5);
    send_item(lfumt_pkg::OP_TOUCH, 6'd63, 3'd7);
    send_item(lfumt_pkg::OP_INVAL, 6'd63, 3'd7);
    send_item(lfumt_pkg::OP_VICTIM, 6'd63, 3'd2);
    send_item(lfumt_pkg::OP_TOUCH, 6'd0, 3'd0);
    send_item(lfumt_pkg::OP_TOUCH, 6'd0, 3'd0);
    send_item(lfumt_pkg::OP_VICTIM, 6'd0, 3'd7);
    send_item(lfumt_pkg::OP_FILL, 6'd0, 3'd4);
    send_item(lfumt_pkg::OP_VICTIM, 6'd0, 3'd1);
    send_item(lfumt_pkg::OP_INVAL, 6'd0, 3'd0);
    send_item(lfumt_pkg::OP_VICTIM, 6'd0, 3'd6);
    // A single coldest way, then an even number of tied ways.
    for (int w = 1; w < WAYS; w++) begin
      send_item(lfumt_pkg::OP_TOUCH, 6'd42, w[WAY_BITS-1:0]);
    end
    send_item(lfumt_pkg::OP_VICTIM, 6'd42, 3'd3);
    send_item(lfumt_pkg::OP_INVAL, 6'd42, 3'd5);
    send_item(lfumt_pkg::OP_VICTIM, 6'd42, 3'd0);
    settle();
  endtask

  task automatic test_heavy_touch();
    for (int w = 0; w < WAYS; w++) send_item(lfumt_pkg::OP_FILL, 6'd21, w[WAY_BITS-1:0]);
    // One way is touched many times and must never be chosen while others tie.
    for (int i = 0; i < HEAVY_TOUCHES; i++) send_item(lfumt_pkg::OP_TOUCH, 6'd21, 3'd3);
    send_item(lfumt_pkg::OP_VICTIM, 6'd21, 3'd0);
    send_item(lfumt_pkg::OP_INVAL, 6'd21, 3'd3);
    send_item(lfumt_pkg::OP_VICTIM, 6'd21, 3'd7);
    settle();
  endtask

  task automatic test_random_traffic(int n);
    int                  r;
    lfumt_pkg::op_e      op;
    logic [SET_BITS-1:0] s;
    logic [SET_BITS-1:0] hot_sets [4];
    hot_sets = '{6'd0, 6'd21, 6'd42, 6'd63};
    for (int i = 0; i < n; i++) begin
      idle_on = (i < (n * 3) / 4);
      r = $urandom_range(0, 99);
      if (r < 30) op = lfumt_pkg::OP_VICTIM;
      else if (r < 60) op = lfumt_pkg::OP_TOUCH;
      else if (r < 75) op = lfumt_pkg::OP_FILL;
      else op = lfumt_pkg::OP_INVAL;
      if ($urandom_range(0, 4) == 0) s = SET_BITS'($urandom_range(0, SETS - 1));
      else s = hot_sets[$urandom_range(0, 3)];
      maybe_pause();
      send_item(op, s, WAY_BITS'($urandom_range(0, WAYS - 1)));
    end
    settle();
  endtask

  initial begin
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) visit_cnt[s][w] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_each_operation();
    test_heavy_touch();
    test_random_traffic(RANDOM_ITEMS);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lfumt_pkg.sv
hdl/lfumt_front.sv
hdl/lfumt_back.sv
hdl/lfu_median_tie_victim_select.sv
tb/tb_lfu_median_tie_victim_select.sv
